/* rtl/core/u8d_pkg.sv */
// ----------------------------------------------------------------------------
// u8d_pkg: shared types and tables of the UTF-8 decoder
// Holds the transfer payload types, the byte class function and the
// automaton transition table.
// ----------------------------------------------------------------------------
`default_nettype none

package u8d_pkg;

    localparam int NUM_STATES  = 9;
    localparam int NUM_CLASSES = 12;

    localparam logic [3:0] ST_ACCEPT = 4'd0;
    localparam logic [3:0] ST_REJECT = 4'd1;
    localparam logic [3:0] ST_LAST   = 4'(NUM_STATES - 1);

    localparam logic [20:0] SURR_LO = 21'h00D800;
    localparam logic [20:0] SURR_HI = 21'h00DFFF;
    localparam logic [20:0] CP_MAX  = 21'h10FFFF;
    localparam logic [20:0] ASCII_END = 21'h000080;

    typedef logic [3:0] t_class;

    localparam t_class CLS_ASCII = 4'd0;

    typedef enum logic [1:0] {
        STATUS_DONE     = 2'd0,
        STATUS_PENDING  = 2'd1,
        STATUS_REJECTED = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [3:0]  automaton_state;
        logic [20:0] code_point;
    } t_out_item;

    // Entry of the queue between the front and the back.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
        t_class     cls;
    } t_q_item;

    localparam logic [3:0] NEXT_STATE [0:NUM_STATES-1][0:NUM_CLASSES-1] = '{
        '{4'd0,4'd1,4'd2,4'd3,4'd5,4'd8,4'd7,4'd1,4'd1,4'd1,4'd4,4'd6},
        '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd0,4'd1,4'd0,4'd1,4'd1},
        '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd2,4'd1,4'd1},
        '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1},
        '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1},
        '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1},
        '{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1},
        '{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1}
    };

    function automatic t_class byte_class(input logic [7:0] b);
        t_class c;
        priority if (b < 8'h80) c = 4'd0;
        else if (b < 8'h90)     c = 4'd1;
        else if (b < 8'hA0)     c = 4'd9;
        else if (b < 8'hC0)     c = 4'd7;
        else if (b < 8'hC2)     c = 4'd8;
        else if (b < 8'hE0)     c = 4'd2;
        else if (b == 8'hE0)    c = 4'd10;
        else if (b == 8'hED)    c = 4'd4;
        else if (b < 8'hF0)     c = 4'd3;
        else if (b == 8'hF0)    c = 4'd11;
        else if (b < 8'hF4)     c = 4'd6;
        else if (b == 8'hF4)    c = 4'd5;
        else                    c = 4'd8;
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/u8d_front.sv */
// ----------------------------------------------------------------------------
// u8d_front: input side of the UTF-8 decoder
// Takes input transfers, sorts each byte into its character class and
// pushes the classified byte into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_front
    import u8d_pkg::*;
(
    input  wire logic     i_in_valid,
    input  t_in_item      i_in_item,
    output logic          o_in_stall,
    input  wire logic     i_q_full,
    output logic          o_push,
    output t_q_item       o_push_item
);

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_push_item.data_byte = i_in_item.data_byte;
        o_push_item.restart   = i_in_item.restart;
        o_push_item.cls       = byte_class(i_in_item.data_byte);
    end

endmodule

`default_nettype wire

/* rtl/core/u8d_queue.sv */
// ----------------------------------------------------------------------------
// u8d_queue: short FIFO between the front and the back
// Decouples the two sides so that each one can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_queue
    import u8d_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_q_item   i_push_item,
    output logic      o_full,
    output logic      o_not_empty,
    input  wire logic i_pop,
    output t_q_item   o_pop_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_q_item r_mem [0:DEPTH-1];

    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    logic do_push, do_pop;

    assign o_full      = (r_count == CNT_FULL);
    assign o_not_empty = (r_count != '0);
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_not_empty;
    assign o_pop_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/u8d_back.sv */
// ----------------------------------------------------------------------------
// u8d_back: automaton and code point accumulator
// Pops classified bytes, steps the automaton, checks finished code points
// and holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_back
    import u8d_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_not_empty,
    input  t_q_item   i_q_item,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  wire logic i_out_stall
);

    logic [3:0]  r_state, n_state;
    logic [20:0] r_cp,    n_cp;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [3:0]  st_cur;
    logic [20:0] cp_cur;
    logic [7:0]  lead_mask;
    logic        bad;

    // A new result may load whenever the output register is empty or drains.
    assign o_pop       = i_q_not_empty && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        st_cur = i_q_item.restart ? ST_ACCEPT : r_state;
        cp_cur = i_q_item.restart ? '0 : r_cp;
        if (st_cur > ST_LAST) begin
            st_cur = ST_REJECT;
        end
        lead_mask = 8'hFF >> i_q_item.cls;
        if (st_cur != ST_ACCEPT) begin
            n_cp = {cp_cur[14:0], i_q_item.data_byte[5:0]};
        end else begin
            n_cp = {13'd0, lead_mask & i_q_item.data_byte};
        end
        n_state = NEXT_STATE[st_cur][i_q_item.cls];
        bad = (n_cp >= SURR_LO && n_cp <= SURR_HI) || (n_cp > CP_MAX)
            || (n_cp < ASCII_END && i_q_item.cls != CLS_ASCII);
        if (n_state == ST_ACCEPT && bad) begin
            n_state = ST_REJECT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACCEPT;
            r_cp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_state     <= n_state;
                r_cp        <= n_cp;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.automaton_state <= n_state;
            r_out.code_point      <= n_cp;
            unique case (n_state)
                ST_ACCEPT: r_out.status <= STATUS_DONE;
                ST_REJECT: r_out.status <= STATUS_REJECTED;
                default:   r_out.status <= STATUS_PENDING;
            endcase
        end
    end

    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state <= ST_LAST)
        else $error("automaton state left the table");

    a_result_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_out.automaton_state == r_state && r_out.code_point == r_cp))
        else $error("result register disagrees with automaton state");

    a_done_means_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.status == STATUS_DONE) == (r_out.automaton_state == ST_ACCEPT)))
        else $error("status does not match automaton state");

endmodule

`default_nettype wire

/* rtl/core/utf8_dfa_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_dfa_decoder: streaming UTF-8 decoder, one byte per transfer
// The input channel (i_in_valid, i_in_item, o_in_stall) carries one raw byte
// and a restart flag per transfer. Restart returns the automaton to accept
// and clears the code point before that byte is decoded.
// The output channel (o_out_valid, o_out_item, i_out_stall) gives exactly one
// result per input byte, in order: status, automaton state and the code point
// accumulated so far, which is complete when status reports done.
// Each accepted byte is written into the queue, then popped into the output
// register, from which its result is offered until it is taken.
// Throughput is one byte per cycle unless the receiver stalls; it is set by
// the state and code point update in the back end, one fed-back table lookup.
// A four-entry queue sits between the classifier front end and the back end,
// so the input keeps accepting while a result waits in the output register.
// When the receiver stalls, the result holds and the queue fills; o_in_stall
// rises once the queue is full and drops as soon as an entry drains.
// Reset empties the queue, drops any pending result and puts the automaton in
// accept with a zero code point. A rejected stream stays rejected until reset
// or a transfer with restart set.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_dfa_decoder
    import u8d_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  wire logic i_out_stall
);

    // Front end to queue.
    logic    push;
    t_q_item push_item;
    logic    q_full;

    // Queue to back end.
    logic    q_not_empty;
    logic    pop;
    t_q_item pop_item;

    u8d_front u_front (
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_item (push_item)
    );

    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_full      (q_full),
        .o_not_empty (q_not_empty),
        .i_pop       (pop),
        .o_pop_item  (pop_item)
    );

    // The back end owns all decoder state; each popped byte becomes a result.
    u8d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (q_not_empty),
        .i_q_item      (pop_item),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .o_out_item    (o_out_item),
        .i_out_stall   (i_out_stall)
    );

endmodule

`default_nettype wire
